// File: hw/rtl/tlca_pkg.sv
// Shared types, constants and helper functions for the two-line closest approach block.
// The top level and the multiplier import this package.
// It has no dependencies.
package tlca_pkg;

  localparam int unsigned COORD_WIDTH = 24;
  localparam int unsigned MUL_BUDGET = 1024;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a1_x;
    coord_t a1_y;
    coord_t a1_z;
    coord_t a2_x;
    coord_t a2_y;
    coord_t a2_z;
    coord_t b1_x;
    coord_t b1_y;
    coord_t b1_z;
    coord_t b2_x;
    coord_t b2_y;
    coord_t b2_z;
  } tlca_in_t;

  typedef struct packed {
    coord_t                 mid_x;
    coord_t                 mid_y;
    coord_t                 mid_z;
    coord_t                 gap_x;
    coord_t                 gap_y;
    coord_t                 gap_z;
    logic [COORD_WIDTH-1:0] distance;
    logic                   parallel;
  } tlca_out_t;

  // Widest digit of the second operand that keeps one partial product within budget.
  function automatic int unsigned mul_dig(input int unsigned aw);
    int unsigned d;
    d = 1;
    for (int unsigned k = 1; k <= 64; k++) begin
      if (aw * k <= MUL_BUDGET) begin
        d = k;
      end
    end
    return d;
  endfunction

  // Stage count of the digit-serial multiplier: sign stage, one stage per digit, sign fix stage.
  function automatic int unsigned mul_lat(input int unsigned aw, input int unsigned bw);
    int unsigned n;
    int unsigned dig;
    dig = mul_dig(aw);
    n = 0;
    for (int unsigned k = 1; k <= 64; k++) begin
      if (n == 0 && k * dig >= bw) begin
        n = k;
      end
    end
    return n + 2;
  endfunction

endpackage

// File: hw/rtl/tlca_delay.sv
// Enabled delay line for data that has to stay aligned with the arithmetic pipeline.
// Depends on nothing.
module tlca_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int unsigned i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

// File: hw/rtl/tlca_mul.sv
// Pipelined signed multiplier that takes the second operand one digit per stage.
// Uses mul_dig and mul_lat from tlca_pkg.
module tlca_mul import tlca_pkg::*; #(
  parameter int unsigned AW = 8,
  parameter int unsigned BW = 8
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int unsigned DIG = mul_dig(AW);
  localparam int unsigned NDIG = mul_lat(AW, BW) - 2;
  localparam int unsigned BPW = NDIG * DIG;
  localparam int unsigned PW = AW + BW;

  logic [AW-1:0]     ma_q  [NDIG];
  logic [BPW-1:0]    mb_q  [NDIG];
  logic              neg_q [NDIG+1];
  logic [PW-1:0]     acc_q [NDIG+1];
  logic [AW+DIG-1:0] pp    [NDIG];
  logic [PW-1:0]     p_q;

  always_comb begin
    for (int unsigned j = 0; j < NDIG; j++) begin
      pp[j] = (AW+DIG)'(ma_q[j]) * (AW+DIG)'(mb_q[j][j*DIG +: DIG]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q[0]  <= a_i[AW-1] ? AW'($unsigned(-a_i)) : AW'($unsigned(a_i));
      mb_q[0]  <= b_i[BW-1] ? BPW'($unsigned(-b_i)) : BPW'($unsigned(b_i));
      neg_q[0] <= a_i[AW-1] ^ b_i[BW-1];
      acc_q[0] <= '0;
      for (int unsigned j = 0; j < NDIG; j++) begin
        acc_q[j+1] <= acc_q[j] + (PW'(pp[j]) << (j * DIG));
        neg_q[j+1] <= neg_q[j];
        if (j + 1 < NDIG) begin
          ma_q[j+1] <= ma_q[j];
          mb_q[j+1] <= mb_q[j];
        end
      end
      p_q <= neg_q[NDIG] ? -acc_q[NDIG] : acc_q[NDIG];
    end
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/tlca_div.sv
// Pipelined restoring divider that rounds to nearest with ties away from zero.
// It returns sign, magnitude and an overflow flag when the quotient exceeds QW bits.
// Depends on nothing.
module tlca_div #(
  parameter int unsigned NUMW = 16,
  parameter int unsigned DENW = 8,
  parameter int unsigned QW   = 8
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic [DENW-1:0]        den_i,
  output logic                   neg_o,
  output logic [QW-1:0]          q_o,
  output logic                   ovf_o
);

  localparam int unsigned RW = NUMW + 1;
  localparam int unsigned XW = (RW > DENW + 1 + QW) ? RW : DENW + 1 + QW;

  logic [NUMW-1:0] mag_q;
  logic            neg1_q;
  logic [DENW-1:0] den1_q;
  logic [XW-1:0]   n2;
  logic [XW-1:0]   d2;

  logic [XW-1:0]   r_q   [QW];
  logic [DENW:0]   d2_q  [QW];
  logic [QW-1:0]   q_q   [QW+1];
  logic            neg_q [QW+1];
  logic            ovf_q [QW+1];
  logic [XW-1:0]   r_nx  [QW];
  logic [QW-1:0]   q_nx  [QW];

  assign n2 = XW'({mag_q, 1'b0}) + XW'(den1_q);
  assign d2 = XW'({den1_q, 1'b0});

  always_comb begin
    for (int unsigned s = 0; s < QW; s++) begin
      logic [XW-1:0] sh;
      sh = XW'(d2_q[s]) << (QW - 1 - s);
      q_nx[s] = q_q[s];
      if (r_q[s] >= sh) begin
        r_nx[s] = r_q[s] - sh;
        q_nx[s][QW-1-s] = 1'b1;
      end else begin
        r_nx[s] = r_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= num_i[NUMW-1] ? NUMW'($unsigned(-num_i)) : NUMW'($unsigned(num_i));
      neg1_q <= num_i[NUMW-1];
      den1_q <= den_i;
      r_q[0]   <= n2;
      d2_q[0]  <= {den1_q, 1'b0};
      q_q[0]   <= '0;
      neg_q[0] <= neg1_q;
      ovf_q[0] <= n2 >= (d2 << QW);
      for (int unsigned s = 0; s < QW; s++) begin
        q_q[s+1]   <= q_nx[s];
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
        if (s + 1 < QW) begin
          r_q[s+1]  <= r_nx[s];
          d2_q[s+1] <= d2_q[s];
        end
      end
    end
  end

  assign neg_o = neg_q[QW];
  assign q_o   = q_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// File: hw/rtl/tlca_sqrt.sv
// Pipelined integer square root, one root bit per stage, rounded to nearest at the end.
// Depends on nothing.
module tlca_sqrt #(
  parameter int unsigned SW = 16,
  parameter int unsigned RB = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] s_i,
  output logic [RB:0]   root_o
);

  localparam int unsigned TW = 2 * RB + 1;

  logic [TW-1:0] rem_q   [RB];
  logic [RB-1:0] root_q  [RB];
  logic [TW-1:0] rem_in  [RB];
  logic [RB-1:0] root_in [RB];
  logic [TW-1:0] rem_nx  [RB];
  logic [RB-1:0] root_nx [RB];
  logic [RB:0]   out_q;

  always_comb begin
    for (int unsigned s = 0; s < RB; s++) begin
      logic [TW-1:0] trial;
      if (s == 0) begin
        rem_in[s]  = TW'(s_i);
        root_in[s] = '0;
      end else begin
        rem_in[s]  = rem_q[s-1];
        root_in[s] = root_q[s-1];
      end
      trial = (TW'(root_in[s]) << (RB - s)) + (TW'(1) << (2 * (RB - 1 - s)));
      root_nx[s] = root_in[s];
      if (rem_in[s] >= trial) begin
        rem_nx[s] = rem_in[s] - trial;
        root_nx[s][RB-1-s] = 1'b1;
      end else begin
        rem_nx[s] = rem_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned s = 0; s < RB; s++) begin
        rem_q[s]  <= rem_nx[s];
        root_q[s] <= root_nx[s];
      end
      out_q <= (rem_q[RB-1] > TW'(root_q[RB-1])) ? (RB+1)'(root_q[RB-1]) + 1'b1
                                                  : (RB+1)'(root_q[RB-1]);
    end
  end

  assign root_o = out_q;

endmodule

// File: hw/rtl/two_line_closest_approach.sv
// Closest approach of two 3D lines given by two points each, Q15.8 fixed point.
// Depends on tlca_pkg, tlca_delay, tlca_mul, tlca_div and tlca_sqrt.
//
// Input channel: in_valid_i, in_stall_o and in_data_i carry one pair of lines per
// transfer. Output channel: out_valid_o, out_stall_i and out_data_o carry the
// midpoint, the separation vector, its length and the parallel flag.
// A transfer happens at a rising edge where valid is high and stall is low.
// The block accepts one item per cycle while in_stall_o is low. Results leave in
// input order; the pipeline depth is set by the two wide multiplier chains, the
// rounding dividers and the square root.
// When the receiver stalls, the pipeline keeps running until the output register
// and the skid register both hold a result, and only then raises in_stall_o.
// Reset clears all valid bits; no result is pending afterwards.
// Parallel or degenerate lines give zero fields with parallel set.
module two_line_closest_approach import tlca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tlca_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tlca_out_t out_data_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DFW  = CW + 1;
  localparam int unsigned PRW  = 2 * DFW;
  localparam int unsigned DW   = PRW + 2;
  localparam int unsigned M1W  = 2 * DW;
  localparam int unsigned NW   = M1W + 1;
  localparam int unsigned M2W  = NW + DFW;
  localparam int unsigned NUMW = M2W + 2;
  localparam int unsigned DENW = NW + 1;
  localparam int unsigned QW   = CW + 2;
  localparam int unsigned SQW  = 2 * QW + 2;
  localparam int unsigned RB   = QW + 1;
  localparam int unsigned ML1  = mul_lat(DW, DW);
  localparam int unsigned ML2  = mul_lat(NW, DFW);
  localparam int unsigned DL   = QW + 2;
  localparam int unsigned SL   = RB + 1;
  localparam int unsigned LAT  = ML1 + ML2 + DL + SL + 7;

  localparam logic [QW-1:0] POS_LIM = QW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (CW - 1));

  typedef logic signed [DFW-1:0] diff_t;
  typedef logic signed [PRW-1:0] prod_t;
  typedef logic signed [DW-1:0]  dot_t;
  typedef logic signed [M2W-1:0] wprod_t;
  typedef logic signed [NUMW-1:0] num_t;

  function automatic coord_t sat_coord(input logic neg, input logic [QW-1:0] mag,
                                       input logic ovf);
    coord_t r;
    if (!neg) begin
      r = (ovf || mag > POS_LIM) ? {1'b0, {(CW-1){1'b1}}} : CW'(mag);
    end else begin
      r = (ovf || mag > NEG_LIM) ? {1'b1, {(CW-1){1'b0}}} : CW'(-mag);
    end
    return r;
  endfunction

  logic adv;
  logic [LAT-1:0] vld_q;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic out_take, load_out, load_skid, out_from_skid;
  tlca_out_t out_q, skid_q, res;

  // Input split, differences, per-axis products and dot products.
  coord_t [2:0] a1, a2, b1, b2;
  diff_t [2:0] v_q, w_q, e_q, base_q;

  assign a1 = {in_data_i.a1_z, in_data_i.a1_y, in_data_i.a1_x};
  assign a2 = {in_data_i.a2_z, in_data_i.a2_y, in_data_i.a2_x};
  assign b1 = {in_data_i.b1_z, in_data_i.b1_y, in_data_i.b1_x};
  assign b2 = {in_data_i.b2_z, in_data_i.b2_y, in_data_i.b2_x};

  prod_t [2:0] vv_q, vw_q, ww_q, ve_q, we_q;
  dot_t a_q, b_q, c_q, d_q, f_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned i = 0; i < 3; i++) begin
        v_q[i]    <= DFW'(a2[i]) - DFW'(a1[i]);
        w_q[i]    <= DFW'(b2[i]) - DFW'(b1[i]);
        e_q[i]    <= DFW'(a1[i]) - DFW'(b1[i]);
        base_q[i] <= DFW'(a1[i]) + DFW'(b1[i]);
        vv_q[i]   <= v_q[i] * v_q[i];
        vw_q[i]   <= v_q[i] * w_q[i];
        ww_q[i]   <= w_q[i] * w_q[i];
        ve_q[i]   <= v_q[i] * e_q[i];
        we_q[i]   <= w_q[i] * e_q[i];
      end
      a_q <= DW'(vv_q[0]) + DW'(vv_q[1]) + DW'(vv_q[2]);
      b_q <= DW'(vw_q[0]) + DW'(vw_q[1]) + DW'(vw_q[2]);
      c_q <= DW'(ww_q[0]) + DW'(ww_q[1]) + DW'(ww_q[2]);
      d_q <= DW'(ve_q[0]) + DW'(ve_q[1]) + DW'(ve_q[2]);
      f_q <= DW'(we_q[0]) + DW'(we_q[1]) + DW'(we_q[2]);
    end
  end

  // Gram determinant and line parameter numerators.
  logic signed [M1W-1:0] ac, bb, bf, cd, af, bd;
  logic signed [NW-1:0] det_q, nt_q, ns_q;

  tlca_mul #(.AW(DW), .BW(DW)) u_mul_ac (.clk_i, .en_i(adv), .a_i(a_q), .b_i(c_q), .p_o(ac));
  tlca_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clk_i, .en_i(adv), .a_i(b_q), .b_i(b_q), .p_o(bb));
  tlca_mul #(.AW(DW), .BW(DW)) u_mul_bf (.clk_i, .en_i(adv), .a_i(b_q), .b_i(f_q), .p_o(bf));
  tlca_mul #(.AW(DW), .BW(DW)) u_mul_cd (.clk_i, .en_i(adv), .a_i(c_q), .b_i(d_q), .p_o(cd));
  tlca_mul #(.AW(DW), .BW(DW)) u_mul_af (.clk_i, .en_i(adv), .a_i(a_q), .b_i(f_q), .p_o(af));
  tlca_mul #(.AW(DW), .BW(DW)) u_mul_bd (.clk_i, .en_i(adv), .a_i(b_q), .b_i(d_q), .p_o(bd));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q <= NW'(ac) - NW'(bb);
      nt_q  <= NW'(bf) - NW'(cd);
      ns_q  <= NW'(af) - NW'(bd);
    end
  end

  diff_t [11:0] vec_bund, vec_dly;
  diff_t [2:0] v_d, w_d, e_d, base_d;

  assign vec_bund = {base_q, e_q, w_q, v_q};
  assign {base_d, e_d, w_d, v_d} = vec_dly;

  tlca_delay #(.WIDTH(12 * DFW), .DEPTH(ML1 + 3)) u_dly_vec (
    .clk_i, .en_i(adv), .d_i(vec_bund), .q_o(vec_dly)
  );

  // Numerators of the gap and midpoint components.
  wprod_t [2:0] edet, tv, sw, bdet;
  logic signed [NW-1:0] det_d;
  num_t [2:0] gnum_q, mnum_q;
  logic [DENW-1:0] den_q;

  for (genvar i = 0; i < 3; i++) begin : g_axis_mul
    tlca_mul #(.AW(NW), .BW(DFW)) u_mul_edet (
      .clk_i, .en_i(adv), .a_i(det_q), .b_i(e_d[i]), .p_o(edet[i])
    );
    tlca_mul #(.AW(NW), .BW(DFW)) u_mul_tv (
      .clk_i, .en_i(adv), .a_i(nt_q), .b_i(v_d[i]), .p_o(tv[i])
    );
    tlca_mul #(.AW(NW), .BW(DFW)) u_mul_sw (
      .clk_i, .en_i(adv), .a_i(ns_q), .b_i(w_d[i]), .p_o(sw[i])
    );
    tlca_mul #(.AW(NW), .BW(DFW)) u_mul_bdet (
      .clk_i, .en_i(adv), .a_i(det_q), .b_i(base_d[i]), .p_o(bdet[i])
    );
  end

  tlca_delay #(.WIDTH(NW), .DEPTH(ML2)) u_dly_det (
    .clk_i, .en_i(adv), .d_i(det_q), .q_o(det_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned i = 0; i < 3; i++) begin
        gnum_q[i] <= NUMW'(edet[i]) + NUMW'(tv[i]) - NUMW'(sw[i]);
        mnum_q[i] <= NUMW'(bdet[i]) + NUMW'(tv[i]) + NUMW'(sw[i]);
      end
      den_q <= {1'b0, det_d};
    end
  end

  // Rounded divisions, saturation, squares of the gap and their rounded square root.
  logic [2:0] g_neg, g_ovf, m_neg, m_ovf;
  logic [2:0][QW-1:0] g_mag, m_mag;
  coord_t [5:0] sat_q, sat_d;
  logic [2:0][2*QW-1:0] gsq_q;
  logic [SQW-1:0] sumsq_q;
  logic [RB:0] root;

  for (genvar i = 0; i < 3; i++) begin : g_axis_div
    tlca_div #(.NUMW(NUMW), .DENW(DENW), .QW(QW)) u_div_gap (
      .clk_i, .en_i(adv), .num_i(gnum_q[i]), .den_i(den_q),
      .neg_o(g_neg[i]), .q_o(g_mag[i]), .ovf_o(g_ovf[i])
    );
    tlca_div #(.NUMW(NUMW), .DENW(DENW), .QW(QW)) u_div_mid (
      .clk_i, .en_i(adv), .num_i(mnum_q[i]), .den_i({den_q[DENW-2:0], 1'b0}),
      .neg_o(m_neg[i]), .q_o(m_mag[i]), .ovf_o(m_ovf[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int unsigned i = 0; i < 3; i++) begin
        sat_q[i]     <= sat_coord(m_neg[i], m_mag[i], m_ovf[i]);
        sat_q[3 + i] <= sat_coord(g_neg[i], g_mag[i], g_ovf[i]);
        gsq_q[i]     <= (2*QW)'(g_mag[i]) * (2*QW)'(g_mag[i]);
      end
      sumsq_q <= SQW'(gsq_q[0]) + SQW'(gsq_q[1]) + SQW'(gsq_q[2]);
    end
  end

  tlca_sqrt #(.SW(SQW), .RB(RB)) u_sqrt (
    .clk_i, .en_i(adv), .s_i(sumsq_q), .root_o(root)
  );

  tlca_delay #(.WIDTH(6 * CW), .DEPTH(SL + 1)) u_dly_sat (
    .clk_i, .en_i(adv), .d_i(sat_q), .q_o(sat_d)
  );

  logic par_g, par_d;

  assign par_g = det_q[NW-1] || (det_q == '0);

  tlca_delay #(.WIDTH(1), .DEPTH(ML2 + DL + SL + 3)) u_dly_par (
    .clk_i, .en_i(adv), .d_i(par_g), .q_o(par_d)
  );

  always_comb begin
    res = '0;
    if (par_d) begin
      res.parallel = 1'b1;
    end else begin
      res.mid_x    = sat_d[0];
      res.mid_y    = sat_d[1];
      res.mid_z    = sat_d[2];
      res.gap_x    = sat_d[3];
      res.gap_y    = sat_d[4];
      res.gap_z    = sat_d[5];
      res.distance = (|root[RB:CW]) ? {CW{1'b1}} : root[CW-1:0];
    end
  end

  // Valid tracking and output register with skid stage.
  assign adv        = !skid_vld_q;
  assign in_stall_o = !adv;
  assign out_take   = out_vld_q && !out_stall_i;

  always_comb begin
    out_vld_d     = out_vld_q;
    skid_vld_d    = skid_vld_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_vld_q) begin
      if (out_take) begin
        out_from_skid = 1'b1;
        skid_vld_d    = 1'b0;
      end
    end else if (vld_q[LAT-1]) begin
      if (!out_vld_q || out_take) begin
        load_out  = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/two_line_closest_approach_test.sv
// Self-checking testbench for the two-line closest approach block.
// Pairs of lines are pushed through the valid/stall input channel and each result is checked
// against a wide-integer predictor. Depends on tlca_pkg and two_line_closest_approach.
module two_line_closest_approach_test;
  import tlca_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int signed COORD_MAX = 8388607;
  localparam int signed COORD_MIN = -8388608;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  tlca_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  tlca_out_t out_data_o;

  tlca_in_t  pending_lines[$];
  tlca_out_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  two_line_closest_approach DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic wide_t round_div(wide_t num, wide_t den);
    wide_t mag;
    wide_t q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic coord_t clamp_coord(wide_t val);
    if (val > wide_t'(COORD_MAX)) begin
      return coord_t'(COORD_MAX);
    end
    if (val < wide_t'(COORD_MIN)) begin
      return coord_t'(COORD_MIN);
    end
    return coord_t'(val);
  endfunction

  function automatic logic [127:0] rounded_sqrt(logic [127:0] sq);
    logic [127:0] root;
    logic [127:0] cand;
    logic [127:0] rem;
    root = '0;
    for (int k = 40; k >= 0; k--) begin
      cand = root | (128'd1 << k);
      if (cand * cand <= sq) begin
        root = cand;
      end
    end
    rem = sq - root * root;
    if (rem > root) begin
      root = root + 1;
    end
    return root;
  endfunction

  function automatic tlca_out_t closest_approach(tlca_in_t lines);
    wide_t pt[12];
    wide_t dir_a[3];
    wide_t dir_b[3];
    wide_t offs[3];
    wide_t base[3];
    wide_t aa, bb, cc, dd, ff, det, nt, ns, tv, sw, gap, mid, sumsq;
    logic [127:0] dist_len;
    coord_t mids[3];
    coord_t gaps[3];
    tlca_out_t res;
    pt[0] = wide_t'(lines.a1_x); pt[1] = wide_t'(lines.a1_y); pt[2] = wide_t'(lines.a1_z);
    pt[3] = wide_t'(lines.a2_x); pt[4] = wide_t'(lines.a2_y); pt[5] = wide_t'(lines.a2_z);
    pt[6] = wide_t'(lines.b1_x); pt[7] = wide_t'(lines.b1_y); pt[8] = wide_t'(lines.b1_z);
    pt[9] = wide_t'(lines.b2_x); pt[10] = wide_t'(lines.b2_y); pt[11] = wide_t'(lines.b2_z);
    aa = 0; bb = 0; cc = 0; dd = 0; ff = 0;
    for (int i = 0; i < 3; i++) begin
      dir_a[i] = pt[3 + i] - pt[i];
      dir_b[i] = pt[9 + i] - pt[6 + i];
      offs[i] = pt[i] - pt[6 + i];
      base[i] = pt[i] + pt[6 + i];
      aa = aa + dir_a[i] * dir_a[i];
      bb = bb + dir_a[i] * dir_b[i];
      cc = cc + dir_b[i] * dir_b[i];
      dd = dd + dir_a[i] * offs[i];
      ff = ff + dir_b[i] * offs[i];
    end
    det = aa * cc - bb * bb;
    res = '0;
    if (det <= 0) begin
      res.parallel = 1'b1;
      return res;
    end
    nt = bb * ff - cc * dd;
    ns = aa * ff - bb * dd;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      tv = dir_a[i] * nt;
      sw = dir_b[i] * ns;
      gap = round_div(offs[i] * det + tv - sw, det);
      mid = round_div(base[i] * det + tv + sw, 2 * det);
      gaps[i] = clamp_coord(gap);
      mids[i] = clamp_coord(mid);
      sumsq = sumsq + gap * gap;
    end
    dist_len = rounded_sqrt(sumsq[127:0]);
    if (dist_len > 128'hFF_FFFF) begin
      dist_len = 128'hFF_FFFF;
    end
    res.mid_x = mids[0]; res.mid_y = mids[1]; res.mid_z = mids[2];
    res.gap_x = gaps[0]; res.gap_y = gaps[1]; res.gap_z = gaps[2];
    res.distance = dist_len[COORD_WIDTH-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic check_result(tlca_out_t got, tlca_out_t want);
    if (got.mid_x !== want.mid_x) report_mismatch("mid_x", got.mid_x, want.mid_x);
    if (got.mid_y !== want.mid_y) report_mismatch("mid_y", got.mid_y, want.mid_y);
    if (got.mid_z !== want.mid_z) report_mismatch("mid_z", got.mid_z, want.mid_z);
    if (got.gap_x !== want.gap_x) report_mismatch("gap_x", got.gap_x, want.gap_x);
    if (got.gap_y !== want.gap_y) report_mismatch("gap_y", got.gap_y, want.gap_y);
    if (got.gap_z !== want.gap_z) report_mismatch("gap_z", got.gap_z, want.gap_z);
    if (got.distance !== want.distance) begin
      report_mismatch("distance", got.distance, want.distance);
    end
    if (got.parallel !== want.parallel) begin
      report_mismatch("parallel", got.parallel, want.parallel);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(closest_approach(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_lines.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= pending_lines.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result at cycle %0d", cycle_count);
          error_count++;
        end else begin
          check_result(out_data_o, expected_results.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic coord_t random_coord(int unsigned kind);
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(4000) - 2000);
      2: return coord_t'($urandom_range(200000) - 100000);
      default: return $urandom_range(1) ? coord_t'(COORD_MAX - $urandom_range(3))
                                         : coord_t'(COORD_MIN + $urandom_range(3));
    endcase
  endfunction

  function automatic tlca_in_t random_lines();
    tlca_in_t lines;
    int unsigned kind;
    int signed scale;
    kind = ($urandom_range(99) < 25) ? 0 : ($urandom_range(99) < 85 ? 1 + $urandom_range(1) : 3);
    lines.a1_x = random_coord(kind); lines.a1_y = random_coord(kind);
    lines.a1_z = random_coord(kind); lines.a2_x = random_coord(kind);
    lines.a2_y = random_coord(kind); lines.a2_z = random_coord(kind);
    lines.b1_x = random_coord(kind); lines.b1_y = random_coord(kind);
    lines.b1_z = random_coord(kind); lines.b2_x = random_coord(kind);
    lines.b2_y = random_coord(kind); lines.b2_z = random_coord(kind);
    case ($urandom_range(19))
      0: begin
        scale = $urandom_range(6) - 3;
        lines.b2_x = coord_t'(lines.b1_x + scale * (lines.a2_x - lines.a1_x));
        lines.b2_y = coord_t'(lines.b1_y + scale * (lines.a2_y - lines.a1_y));
        lines.b2_z = coord_t'(lines.b1_z + scale * (lines.a2_z - lines.a1_z));
      end
      1: begin
        lines.a2_x = lines.a1_x; lines.a2_y = lines.a1_y; lines.a2_z = lines.a1_z;
      end
      2: begin
        lines.b1_x = lines.a1_x; lines.b1_y = lines.a1_y; lines.b1_z = lines.a1_z;
      end
      default: begin
      end
    endcase
    return lines;
  endfunction

  task automatic wait_until_drained();
    while (pending_lines.size() > 0 || in_valid_i || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    coord_t hi;
    coord_t lo;
    hi = coord_t'(COORD_MAX);
    lo = coord_t'(COORD_MIN);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_lines.push_back('0);
    pending_lines.push_back(tlca_in_t'{0, 0, 0, 256, 0, 0, 0, 0, 256, 0, 256, 256});
    pending_lines.push_back(tlca_in_t'{0, 0, 0, 256, 0, 0, 0, 0, 0, 0, 256, 0});
    pending_lines.push_back(tlca_in_t'{0, 0, 0, 256, 0, 0, 0, 256, 0, 512, 256, 0});
    pending_lines.push_back(tlca_in_t'{5, 7, 9, 5, 7, 9, 1, 2, 3, 4, 5, 6});
    pending_lines.push_back(tlca_in_t'{1, 2, 3, 4, 5, 6, 9, 9, 9, 9, 9, 9});
    pending_lines.push_back(tlca_in_t'{lo, lo, lo, hi, hi, hi, lo, hi, lo, hi, lo, hi});
    pending_lines.push_back(tlca_in_t'{hi, hi, hi, lo, lo, lo, hi, lo, hi, lo, hi, lo});
    pending_lines.push_back(tlca_in_t'{lo, lo, lo, lo, lo, hi, hi, hi, hi, hi, lo, hi});
    pending_lines.push_back(tlca_in_t'{hi, lo, 0, hi, lo, 1, lo, hi, 0, lo, hi, 1});
    pending_lines.push_back(tlca_in_t'{hi, 0, 0, hi, 1, 0, lo, 0, 0, lo, 0, 1});
    pending_lines.push_back(tlca_in_t'{0, 0, hi, 1, 0, hi, 0, 0, lo, 0, 1, lo});
    pending_lines.push_back(tlca_in_t'{lo, lo, lo, hi, hi, hi, hi, lo, hi, lo, hi, lo});
    pending_lines.push_back(tlca_in_t'{1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 0});
    pending_lines.push_back(tlca_in_t'{-3, 1, 0, 3, 1, 0, 0, -1, 1, 0, 1, 2});
    pending_lines.push_back(tlca_in_t'{0, 0, 0, 3, 3, 3, 1, 0, 0, 4, 3, 3});
    pending_lines.push_back(tlca_in_t'{hi, hi, hi, hi, hi, lo, lo, lo, lo, hi, lo, lo});

    // Hold the sender off until the pipeline has fully drained.
    wait_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 50; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 50; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int n = 0; n < 285; n++) begin
        pending_lines.push_back(random_lines());
      end
      while (pending_lines.size() > 0) begin
        @(posedge clk_i);
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() > 0) begin
      $display("%0d results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: two_line_closest_approach.f
hw/rtl/tlca_pkg.sv
hw/rtl/tlca_delay.sv
hw/rtl/tlca_mul.sv
hw/rtl/tlca_div.sv
hw/rtl/tlca_sqrt.sv
hw/rtl/two_line_closest_approach.sv
tb/sv/two_line_closest_approach_test.sv
